[hdl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation matrix to quaternion unit
// Holds the fixed-point format, derived datapath widths and payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rmq_pkg;

	localparam int W = 16;   // data width
	localparam int F = 14;   // fraction bits

	localparam int DW   = W + 2;                        // trace combination d
	localparam int AW   = W + 1;                        // off-diagonal sum or difference
	localparam int SW   = 2 * AW + 2;                   // sum of three squares
	localparam int NW   = SW + F;                       // dividend
	localparam int QW   = NW - F - 1;                   // quotient bits that can be set
	localparam int DENW = ((F > W) ? F : W) + 3;        // divisor 3*ONE - d
	localparam int RW   = DENW + 1;                     // partial remainder
	localparam int PW   = ((F > DW - 1) ? F : DW - 1) + 1 + F; // (ONE + d) << F
	localparam int SQW  = (QW > PW) ? QW : PW;
	localparam int SQW2 = SQW + (SQW % 2);              // radicand, even width
	localparam int SR   = SQW2 / 2;                     // root bits
	localparam int MW   = W - 1;                        // lane magnitude
	localparam int LAT  = QW + SR + 3;                  // lane pipeline depth

	typedef struct packed {
		logic signed [W-1:0] m00;
		logic signed [W-1:0] m01;
		logic signed [W-1:0] m02;
		logic signed [W-1:0] m10;
		logic signed [W-1:0] m11;
		logic signed [W-1:0] m12;
		logic signed [W-1:0] m20;
		logic signed [W-1:0] m21;
		logic signed [W-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [W-1:0] quat_w;
		logic signed [W-1:0] quat_x;
		logic signed [W-1:0] quat_y;
		logic signed [W-1:0] quat_z;
	} quat_t;

	// Control that travels beside the lanes: request valid and the signs.
	typedef struct packed {
		logic vld;
		logic neg_x;
		logic neg_y;
		logic neg_z;
	} ctl_t;

endpackage

[hdl/rotation_matrix_to_quaternion_unit.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: 3x3 rotation matrix to unit quaternion
// Four component lanes run side by side; a merge stage applies the signs.
// ----------------------------------------------------------------------------
// Matrix entries and quaternion components are Q2.14. Each lane is a pipeline of
//   one-bit-per-stage divider and square-root stages.
// Throughput: one request per cycle; the whole pipeline holds while the output
//   register is full and not taken.
// Reset clears the control entries and the output valid; data registers are not reset.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mat_valid,
	output logic           mat_ready,
	input  rmq_pkg::mat_t  mat,
	output logic           quat_valid,
	input  logic           quat_ready,
	output rmq_pkg::quat_t quat
);
	localparam int DW  = rmq_pkg::DW;
	localparam int AW  = rmq_pkg::AW;
	localparam int LAT = rmq_pkg::LAT;

	// Sign-extended diagonal entries for the trace combinations.
	logic signed [DW-1:0] e00, e11, e22;
	logic signed [DW-1:0] dw, dx_tr, dy_tr, dz_tr;

	// Antisymmetric differences (also give the x, y, z signs) and symmetric sums.
	logic signed [AW-1:0] ax, ay, az, sxy, sxz, syz;

	logic adv;
	logic [rmq_pkg::MW-1:0] mag_w, mag_x, mag_y, mag_z;

	// Valid and sign bits ride alongside the lanes, one entry per lane stage.
	rmq_pkg::ctl_t ctl_q [LAT];

	assign e00 = DW'(mat.m00);
	assign e11 = DW'(mat.m11);
	assign e22 = DW'(mat.m22);

	assign dw    =  e00 + e11 + e22;
	assign dx_tr =  e00 - e11 - e22;
	assign dy_tr = -e00 + e11 - e22;
	assign dz_tr = -e00 - e11 + e22;

	assign ax  = AW'(mat.m21) - AW'(mat.m12);
	assign ay  = AW'(mat.m02) - AW'(mat.m20);
	assign az  = AW'(mat.m10) - AW'(mat.m01);
	assign sxy = AW'(mat.m01) + AW'(mat.m10);
	assign sxz = AW'(mat.m20) + AW'(mat.m02);
	assign syz = AW'(mat.m12) + AW'(mat.m21);

	// A request enters whenever the pipeline moves.
	assign mat_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				ctl_q[k] <= '0;
			end
		end else if (adv) begin
			ctl_q[0] <= '{vld: mat_valid, neg_x: ax[AW-1], neg_y: ay[AW-1], neg_z: az[AW-1]};
			for (int k = 1; k < LAT; k++) begin
				ctl_q[k] <= ctl_q[k-1];
			end
		end
	end

	rmq_lane u_lane_w (.clk(clk), .en(adv), .d(dw), .a(ax), .b(ay), .c(az), .mag(mag_w));
	rmq_lane u_lane_x (.clk(clk), .en(adv), .d(dx_tr), .a(ax), .b(sxy), .c(sxz), .mag(mag_x));
	rmq_lane u_lane_y (.clk(clk), .en(adv), .d(dy_tr), .a(ay), .b(sxy), .c(syz), .mag(mag_y));
	rmq_lane u_lane_z (.clk(clk), .en(adv), .d(dz_tr), .a(az), .b(sxz), .c(syz), .mag(mag_z));

	rmq_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_q[LAT-1]),
		.mag_w      (mag_w),
		.mag_x      (mag_x),
		.mag_y      (mag_y),
		.mag_z      (mag_z),
		.adv        (adv),
		.quat_valid (quat_valid),
		.quat_ready (quat_ready),
		.quat       (quat)
	);

endmodule

[hdl/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div: pipelined restoring divider
// One quotient bit per stage; carries the positive-branch radicand alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmq_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [rmq_pkg::NW-1:0]   num,
	input  logic [rmq_pkg::DENW-1:0] den,
	input  logic                     pos,
	input  logic [rmq_pkg::PW-1:0]   px,
	output logic [rmq_pkg::QW-1:0]   quo,
	output logic                     pos_out,
	output logic [rmq_pkg::PW-1:0]   px_out
);
	localparam int QW = rmq_pkg::QW;
	localparam int RW = rmq_pkg::RW;

	logic [RW-1:0]            rem_q  [QW];
	logic [QW-1:0]            bits_q [QW];
	logic [rmq_pkg::DENW-1:0] den_q  [QW];
	logic                     pos_q  [QW];
	logic [rmq_pkg::PW-1:0]   px_q   [QW];

	logic [RW-1:0]            rem_n  [QW];
	logic [QW-1:0]            bits_n [QW];
	logic [rmq_pkg::DENW-1:0] den_n  [QW];

	always_comb begin
		logic [RW-1:0]            srem;
		logic [QW-1:0]            sbits;
		logic [rmq_pkg::DENW-1:0] sden;
		logic [RW-1:0]            t;
		logic                     ge;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				// The top bits are below the divisor, so they start as remainder.
				srem  = RW'(num[rmq_pkg::NW-1:QW]);
				sbits = num[QW-1:0];
				sden  = den;
			end else begin
				srem  = rem_q[k-1];
				sbits = bits_q[k-1];
				sden  = den_q[k-1];
			end
			t         = {srem[RW-2:0], sbits[QW-1]};
			ge        = (t >= RW'(sden));
			rem_n[k]  = ge ? (t - RW'(sden)) : t;
			bits_n[k] = {sbits[QW-2:0], ge};
			den_n[k]  = sden;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_q[k]  <= rem_n[k];
				bits_q[k] <= bits_n[k];
				den_q[k]  <= den_n[k];
				if (k == 0) begin
					pos_q[k] <= pos;
					px_q[k]  <= px;
				end else begin
					pos_q[k] <= pos_q[k-1];
					px_q[k]  <= px_q[k-1];
				end
			end
		end
	end

	assign quo     = bits_q[QW-1];
	assign pos_out = pos_q[QW-1];
	assign px_out  = px_q[QW-1];

endmodule

[hdl/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt: pipelined truncating integer square root
// Two radicand bits and one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmq_sqrt (
	input  logic                     clk,
	input  logic                     en,
	input  logic [rmq_pkg::SQW2-1:0] x,
	output logic [rmq_pkg::SR-1:0]   root
);
	localparam int SR = rmq_pkg::SR;
	localparam int XW = rmq_pkg::SQW2;

	logic [SR+1:0] rem_q  [SR];
	logic [SR-1:0] root_q [SR];
	logic [XW-1:0] x_q    [SR];

	logic [SR+1:0] rem_n  [SR];
	logic [SR-1:0] root_n [SR];
	logic [XW-1:0] x_n    [SR];

	always_comb begin
		logic [SR+1:0] srem;
		logic [SR-1:0] sroot;
		logic [XW-1:0] sx;
		logic [SR+1:0] t;
		logic [SR+1:0] trial;
		logic          ge;
		for (int k = 0; k < SR; k++) begin
			if (k == 0) begin
				srem  = '0;
				sroot = '0;
				sx    = x;
			end else begin
				srem  = rem_q[k-1];
				sroot = root_q[k-1];
				sx    = x_q[k-1];
			end
			// The remainder stays below 2^SR until the last stage.
			t         = {srem[SR-1:0], sx[XW-1 -: 2]};
			trial     = {sroot, 2'b01};
			ge        = (t >= trial);
			rem_n[k]  = ge ? (t - trial) : t;
			root_n[k] = {sroot[SR-2:0], ge};
			x_n[k]    = {sx[XW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SR; k++) begin
				rem_q[k]  <= rem_n[k];
				root_q[k] <= root_n[k];
				x_q[k]    <= x_n[k];
			end
		end
	end

	assign root = root_q[SR-1];

endmodule

[hdl/rmq_lane.sv]
// ----------------------------------------------------------------------------
// rmq_lane: magnitude of one quaternion component
// Squares, dividend and divisor, then divider, square root and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmq_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [rmq_pkg::DW-1:0] d,
	input  logic signed [rmq_pkg::AW-1:0] a,
	input  logic signed [rmq_pkg::AW-1:0] b,
	input  logic signed [rmq_pkg::AW-1:0] c,
	output logic [rmq_pkg::MW-1:0]        mag
);
	localparam int AW   = rmq_pkg::AW;
	localparam int DENW = rmq_pkg::DENW;
	localparam int PW   = rmq_pkg::PW;
	localparam int SW   = rmq_pkg::SW;
	localparam int F    = rmq_pkg::F;
	localparam logic signed [DENW:0] THREE_ONE = (DENW+1)'(3) <<< F;
	localparam logic [PW-1:0]        ONE_P     = PW'(1) << F;
	localparam logic [rmq_pkg::SR-1:0] POS_MAX = rmq_pkg::SR'((1 << rmq_pkg::MW) - 1);

	logic [AW-1:0]        ma, mb, mc;
	logic signed [DENW:0] dext;

	logic [2*AW-1:0]      sqa_s1, sqb_s1, sqc_s1;
	logic [DENW-1:0]      den_s1, den_s2;
	logic                 pos_s1, pos_s2;
	logic [PW-1:0]        px_s1, px_s2;
	logic [rmq_pkg::NW-1:0] num_s2;

	logic [rmq_pkg::QW-1:0] quo;
	logic                   pos_d;
	logic [PW-1:0]          px_d;
	logic [rmq_pkg::SQW2-1:0] rad;
	logic [rmq_pkg::SR-1:0]   root;
	logic [rmq_pkg::SR-1:0]   half;
	logic [rmq_pkg::MW-1:0]   mag_q;

	assign ma   = a[AW-1] ? AW'(-a) : AW'(a);
	assign mb   = b[AW-1] ? AW'(-b) : AW'(b);
	assign mc   = c[AW-1] ? AW'(-c) : AW'(c);
	assign dext = (DENW+1)'(d);

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s1 <= ma * ma;
			sqb_s1 <= mb * mb;
			sqc_s1 <= mc * mc;
			den_s1 <= DENW'(THREE_ONE - dext);
			pos_s1 <= (d > 0);
			px_s1  <= (ONE_P + PW'(d)) << F;
			num_s2 <= {SW'(sqa_s1) + SW'(sqb_s1) + SW'(sqc_s1), F'(0)};
			den_s2 <= den_s1;
			pos_s2 <= pos_s1;
			px_s2  <= px_s1;
		end
	end

	rmq_div u_div (
		.clk     (clk),
		.en      (en),
		.num     (num_s2),
		.den     (den_s2),
		.pos     (pos_s2),
		.px      (px_s2),
		.quo     (quo),
		.pos_out (pos_d),
		.px_out  (px_d)
	);

	assign rad = pos_d ? rmq_pkg::SQW2'(px_d) : rmq_pkg::SQW2'(quo);

	rmq_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (rad),
		.root (root)
	);

	assign half = root >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= (half > POS_MAX) ? rmq_pkg::MW'(POS_MAX) : rmq_pkg::MW'(half);
		end
	end

	assign mag = mag_q;

endmodule

[hdl/rmq_merge.sv]
// ----------------------------------------------------------------------------
// rmq_merge: combines lane magnitudes with signs into the output register
// Also produces the pipeline advance that stalls everything upstream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmq_merge (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rmq_pkg::ctl_t          ctl,
	input  logic [rmq_pkg::MW-1:0] mag_w,
	input  logic [rmq_pkg::MW-1:0] mag_x,
	input  logic [rmq_pkg::MW-1:0] mag_y,
	input  logic [rmq_pkg::MW-1:0] mag_z,
	output logic                   adv,
	output logic                   quat_valid,
	input  logic                   quat_ready,
	output rmq_pkg::quat_t         quat
);
	localparam int W = rmq_pkg::W;

	logic           valid_q;
	rmq_pkg::quat_t quat_q;
	logic [W-1:0]   ux, uy, uz;

	assign adv = !valid_q || quat_ready;
	assign ux  = {1'b0, mag_x};
	assign uy  = {1'b0, mag_y};
	assign uz  = {1'b0, mag_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl.vld) begin
			quat_q.quat_w <= {1'b0, mag_w};
			quat_q.quat_x <= ctl.neg_x ? W'(-ux) : ux;
			quat_q.quat_y <= ctl.neg_y ? W'(-uy) : uy;
			quat_q.quat_z <= ctl.neg_z ? W'(-uz) : uz;
		end
	end

	assign quat_valid = valid_q;
	assign quat       = quat_q;

endmodule

[hdl/rmq_checker.sv]
// ----------------------------------------------------------------------------
// rmq_checker: port-level assertions for the quaternion unit
// Bound to the top level; watches the handshakes and the scalar part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           mat_valid,
	input logic           mat_ready,
	input rmq_pkg::mat_t  mat,
	input logic           quat_valid,
	input logic           quat_ready,
	input rmq_pkg::quat_t quat
);

	// A stalled result stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat_ready |=> quat_valid)
		else $error("result dropped while stalled");

	// The scalar part is never negative.
	a_w_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid |-> !quat.quat_w[rmq_pkg::W-1])
		else $error("negative scalar part");

	// A full, untaken output stalls the input side.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat_ready |-> !mat_ready)
		else $error("request taken while output stalled");

	// With the output free, the input is always ready.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!quat_valid |-> mat_ready)
		else $error("input blocked with free output");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);

[tb/rotation_matrix_to_quaternion_unit_check.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_check: quaternion predictor and scoreboard
// Watches both channels, predicts each quaternion and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_check (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mat_valid,
	input  logic           mat_ready,
	input  rmq_pkg::mat_t  mat,
	input  logic           quat_valid,
	input  logic           quat_ready,
	input  rmq_pkg::quat_t quat,
	output int             errors,
	output int             pending
);
	localparam int W = rmq_pkg::W;
	localparam int F = rmq_pkg::F;
	localparam longint ONE = longint'(1) << F;
	localparam longint POS_MAX = (longint'(1) << (W - 1)) - 1;

	rmq_pkg::quat_t quat_queue[$];

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = longint'(1) << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Magnitude of one quaternion component from its trace combination.
	function automatic longint comp_mag(longint d, longint a, longint b, longint c);
		logic [127:0] s;
		longint unsigned r;
		if (d > 0) begin
			r = root_floor(longint'(ONE + d) << F) >> 1;
		end else begin
			s = 128'(a * a) + 128'(b * b) + 128'(c * c);
			s = (s << F) / 128'(3 * ONE - d);
			r = root_floor(s[63:0]) >> 1;
		end
		if (r > POS_MAX)
			r = POS_MAX;
		return longint'(r);
	endfunction

	function automatic rmq_pkg::quat_t predict_quat(rmq_pkg::mat_t m);
		longint dx, dy, dz, sxy, sxz, syz, a0, a1, a2;
		rmq_pkg::quat_t q;
		a0 = m.m00;
		a1 = m.m11;
		a2 = m.m22;
		dx = longint'(m.m21) - m.m12;
		dy = longint'(m.m02) - m.m20;
		dz = longint'(m.m10) - m.m01;
		sxy = longint'(m.m01) + m.m10;
		sxz = longint'(m.m20) + m.m02;
		syz = longint'(m.m12) + m.m21;
		q.quat_w = W'(comp_mag(a0 + a1 + a2, dx, dy, dz));
		q.quat_x = W'((dx < 0 ? -1 : 1) * comp_mag(a0 - a1 - a2, dx, sxy, sxz));
		q.quat_y = W'((dy < 0 ? -1 : 1) * comp_mag(-a0 + a1 - a2, dy, sxy, syz));
		q.quat_z = W'((dz < 0 ? -1 : 1) * comp_mag(-a0 - a1 + a2, dz, sxz, syz));
		return q;
	endfunction

	assign pending = quat_queue.size();

	initial errors = 0;

	always @(posedge clk) begin
		rmq_pkg::quat_t exp_q;
		if (arst_n) begin
			if (mat_valid && mat_ready)
				quat_queue.push_back(predict_quat(mat));
			if (quat_valid && quat_ready) begin
				if (quat_queue.size() == 0) begin
					$display("%0t: unexpected quaternion %h", $time, quat);
					errors++;
				end else begin
					exp_q = quat_queue.pop_front();
					if (exp_q.quat_w !== quat.quat_w || exp_q.quat_x !== quat.quat_x ||
					    exp_q.quat_y !== quat.quat_y || exp_q.quat_z !== quat.quat_z) begin
						$display({"%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d",
							" actual w=%0d x=%0d y=%0d z=%0d"},
							$time, exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
							quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
						errors++;
					end
				end
			end
		end
	end
endmodule

[tb/rotation_matrix_to_quaternion_unit_test.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_test: stimulus and verdict
// Drives directed and random matrices with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_test;
	localparam int W = rmq_pkg::W;
	localparam int ONE = 1 << rmq_pkg::F;
	localparam int N_RANDOM = 1930;

	logic            clk;
	logic            arst_n;
	logic            mat_valid;
	logic            mat_ready;
	rmq_pkg::mat_t   mat;
	logic            quat_valid;
	logic            quat_ready;
	rmq_pkg::quat_t  quat;
	int              errors;
	int              pending;
	bit              stim_done;

	rotation_matrix_to_quaternion_unit DUT (.*);

	rotation_matrix_to_quaternion_unit_check checker_i (
		.clk(clk), .arst_n(arst_n), .mat_valid(mat_valid), .mat_ready(mat_ready),
		.mat(mat), .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one, sometimes none at all.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// One request: hold valid at the falling edge until a rising edge takes it.
	// Valid drops only when a gap follows, so back-to-back requests keep it high.
	task automatic send_matrix(rmq_pkg::mat_t m);
		int g;
		g = gap_len();
		if (g > 0) begin
			mat_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		mat <= m;
		mat_valid <= 1'b1;
		@(posedge clk);
		while (!mat_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [W-1:0] rand_entry(int kind);
		case (kind)
			0: return W'($urandom);
			1: return W'($signed($urandom_range(0, 2 * ONE)) - ONE);
			default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	// Near-rotation: a random cyclic axis permutation with random signs plus small noise.
	function automatic rmq_pkg::mat_t rand_rotation();
		logic signed [W-1:0] e [9];
		int p;
		int sgn;
		rmq_pkg::mat_t m;
		p = $urandom_range(0, 2);
		for (int i = 0; i < 9; i++)
			e[i] = W'($signed($urandom_range(0, 800)) - 400);
		for (int r = 0; r < 3; r++) begin
			sgn = $urandom_range(0, 1) ? 1 : -1;
			e[r * 3 + (r + p) % 3] = W'(sgn * (ONE - int'($urandom_range(0, 6000))));
		end
		m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		return m;
	endfunction

	initial begin
		rmq_pkg::mat_t m;
		int kind;
		arst_n = 1'b0;
		mat_valid = 1'b0;
		mat = '0;
		stim_done = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: identity, half turns, quarter turns about z, zero, and field extremes.
		send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
			16'sd0, 16'sd0, 16'sd16384});
		send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
			16'sd0, 16'sd0, -16'sd16384});
		send_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
			16'sd0, 16'sd0, -16'sd16384});
		send_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
			16'sd0, 16'sd0, 16'sd16384});
		send_matrix({16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
			16'sd0, 16'sd0, 16'sd16384});
		send_matrix({16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
			16'sd0, 16'sd0, 16'sd16384});
		send_matrix('0);
		send_matrix({9{16'sh7fff}});
		send_matrix({9{16'sh8000}});
		send_matrix({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
		send_matrix({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
		send_matrix({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000});
		send_matrix({16'sh8000, 16'sh0, 16'sh0, 16'sh0, 16'sh8000, 16'sh0,
			16'sh0, 16'sh0, 16'sh8000});
		send_matrix({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
		send_matrix({16'shffff, 16'sh1, 16'shffff, 16'sh1, 16'shffff, 16'sh1,
			16'shffff, 16'sh1, 16'shffff});

		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				m = rand_rotation();
			end else begin
				for (int k = 0; k < 9; k++)
					m[k*W +: W] = rand_entry(kind == 9 ? 2 : kind - 6);
			end
			send_matrix(m);
		end
		mat_valid <= 1'b0;
		stim_done = 1;
	end

	// Output side stalls at random, with stretches of steady readiness.
	initial begin
		int g;
		quat_ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0) begin
				g = gap_len();
				if (g > 0) begin
					quat_ready <= 1'b0;
					repeat (g) @(negedge clk);
				end
			end
			quat_ready <= 1'b1;
		end
	end

	initial begin
		wait (stim_done);
		while (pending != 0)
			@(posedge clk);
		repeat (rmq_pkg::LAT + 20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

[sim.f]
hdl/rmq_pkg.sv
hdl/rmq_div.sv
hdl/rmq_sqrt.sv
hdl/rmq_lane.sv
hdl/rmq_merge.sv
hdl/rotation_matrix_to_quaternion_unit.sv
hdl/rmq_checker.sv
tb/rotation_matrix_to_quaternion_unit_check.sv
tb/rotation_matrix_to_quaternion_unit_test.sv
